/* hw/rtl/olie_pkg.sv */
// field widths, operation kinds and status codes of the ordered list
// depends on nothing; used by ordered_list_insert_erase
package olie_pkg;

  localparam int KIND_W   = 3;
  localparam int POS_W    = 5;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_BACK = 3'd0,
    KIND_POP_BACK  = 3'd1,
    KIND_POP_FRONT = 3'd2,
    KIND_INSERT    = 3'd3,
    KIND_ERASE     = 3'd4,
    KIND_DUMP      = 3'd5
  } kind_t;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_POS   = 2'd3;

endpackage

/* hw/rtl/ordered_list_insert_erase.sv */
// ordered list of signed words held in one synchronous memory, with
// insert/erase/pop front done as one-entry-per-cycle shift sweeps
// depends on olie_pkg
//
//  channel   direction  handshake            payload
//  request   in         req_valid/req_stall  kind, position, value
//  result    out        res_valid/res_stall  status, count, element, last
//
// push back, pop back and every failed request go from idle straight to the emit state.
// pop front, erase and insert run a shift sweep over the entries that move; the sweep
// reads one entry and writes its neighbor per cycle on the single memory port pair,
// then drains one pending write.
// dump: each element is read in DUMP_RD and then emitted from DUMP_EMIT.
// a request is taken only while no earlier one is being worked on; a waiting
// result does not block it. a stalled result holds the block at its next emit.
// synchronous reset empties the list; memory contents are not cleared.
module ordered_list_insert_erase #(
  parameter int DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 req_stall,
  input  logic [olie_pkg::KIND_W-1:0]          kind,
  input  logic [olie_pkg::POS_W-1:0]           position,
  input  logic signed [olie_pkg::DATA_W-1:0]   value,
  output logic                                 res_valid,
  input  logic                                 res_stall,
  output logic [olie_pkg::STATUS_W-1:0]        status,
  output logic [olie_pkg::COUNT_W-1:0]         count,
  output logic signed [olie_pkg::DATA_W-1:0]   element,
  output logic                                 last
);

  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > olie_pkg::POS_W) ? CW : olie_pkg::POS_W;

  typedef enum logic [2:0] {
    IDLE,
    SHIFT,
    EMIT,
    DUMP_RD,
    DUMP_EMIT
  } state_t;

  state_t                        state;
  logic [CW-1:0]                 cnt;
  logic [IW-1:0]                 ptr;
  logic [IW-1:0]                 last_addr;
  logic [CW-1:0]                 rem;
  logic                          pend;
  olie_pkg::kind_t               op_kind;
  logic [IW-1:0]                 op_pos;
  logic [olie_pkg::DATA_W-1:0]   op_value;
  logic [olie_pkg::STATUS_W-1:0] emit_status;

  logic [olie_pkg::DATA_W-1:0] mem [DEPTH];
  logic [olie_pkg::DATA_W-1:0] rd_data;
  logic                        we;
  logic                        re;
  logic [IW-1:0]               waddr;
  logic [IW-1:0]               raddr;
  logic [olie_pkg::DATA_W-1:0] wdata;

  logic out_free;
  logic emit_go;
  logic full;
  logic pos_lt;
  logic shift_left;

  assign req_stall  = (state != IDLE);
  assign out_free   = !res_valid || !res_stall;
  assign emit_go    = (state == EMIT || state == DUMP_EMIT) && out_free;
  assign full       = (cnt >= CW'(DEPTH));
  assign pos_lt     = (CMPW'(position) < CMPW'(cnt));
  assign shift_left = (op_kind != olie_pkg::KIND_INSERT);

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = ptr;
    if (state == IDLE && req_valid && kind == olie_pkg::KIND_PUSH_BACK && !full) begin
      we    = 1'b1;
      waddr = IW'(cnt);
      wdata = value;
    end else if (state == SHIFT) begin
      if (pend) begin
        we    = 1'b1;
        waddr = shift_left ? (last_addr - IW'(1)) : (last_addr + IW'(1));
        wdata = rd_data;
      end else if (rem == '0 && !shift_left) begin
        // the freed slot takes the inserted value
        we    = 1'b1;
        waddr = op_pos;
        wdata = op_value;
      end
      re = (rem != '0);
    end else if (state == DUMP_RD) begin
      re = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      cnt       <= '0;
      pend      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (emit_go) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (req_valid) begin
            op_kind  <= olie_pkg::kind_t'(kind);
            op_pos   <= IW'(position);
            op_value <= value;
            pend     <= 1'b0;
            priority case (kind)
              olie_pkg::KIND_PUSH_BACK: begin
                if (full) begin
                  emit_status <= olie_pkg::ST_FULL;
                end else begin
                  emit_status <= olie_pkg::ST_OK;
                  cnt         <= cnt + CW'(1);
                end
                state <= EMIT;
              end
              olie_pkg::KIND_POP_BACK: begin
                if (cnt == '0) begin
                  emit_status <= olie_pkg::ST_EMPTY;
                end else begin
                  emit_status <= olie_pkg::ST_OK;
                  cnt         <= cnt - CW'(1);
                end
                state <= EMIT;
              end
              olie_pkg::KIND_POP_FRONT: begin
                if (cnt == '0) begin
                  emit_status <= olie_pkg::ST_EMPTY;
                  state       <= EMIT;
                end else begin
                  op_pos <= '0;
                  ptr    <= IW'(1);
                  rem    <= cnt - CW'(1);
                  state  <= SHIFT;
                end
              end
              olie_pkg::KIND_INSERT: begin
                if (full) begin
                  emit_status <= olie_pkg::ST_FULL;
                  state       <= EMIT;
                end else if (!pos_lt) begin
                  emit_status <= olie_pkg::ST_POS;
                  state       <= EMIT;
                end else begin
                  // sweep downward from the tail
                  ptr   <= IW'(cnt - CW'(1));
                  rem   <= cnt - CW'(position);
                  state <= SHIFT;
                end
              end
              olie_pkg::KIND_ERASE: begin
                if (cnt == '0) begin
                  emit_status <= olie_pkg::ST_EMPTY;
                  state       <= EMIT;
                end else if (!pos_lt) begin
                  emit_status <= olie_pkg::ST_POS;
                  state       <= EMIT;
                end else begin
                  ptr   <= IW'(position) + IW'(1);
                  rem   <= cnt - CW'(1) - CW'(position);
                  state <= SHIFT;
                end
              end
              olie_pkg::KIND_DUMP: begin
                if (cnt == '0) begin
                  emit_status <= olie_pkg::ST_EMPTY;
                  state       <= EMIT;
                end else begin
                  ptr   <= '0;
                  rem   <= cnt;
                  state <= DUMP_RD;
                end
              end
              default: begin
                // unused kinds are dropped without a result
              end
            endcase
          end
        end
        SHIFT: begin
          if (rem != '0) begin
            last_addr <= ptr;
            ptr       <= shift_left ? (ptr + IW'(1)) : (ptr - IW'(1));
            rem       <= rem - CW'(1);
            pend      <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (rem == '0 && !pend) begin
            cnt         <= shift_left ? (cnt - CW'(1)) : (cnt + CW'(1));
            emit_status <= olie_pkg::ST_OK;
            state       <= EMIT;
          end
        end
        EMIT: begin
          if (out_free) begin
            status    <= emit_status;
            count     <= olie_pkg::COUNT_W'(cnt);
            element   <= '0;
            last      <= 1'b1;
            state     <= IDLE;
          end
        end
        DUMP_RD: begin
          ptr   <= ptr + IW'(1);
          rem   <= rem - CW'(1);
          state <= DUMP_EMIT;
        end
        DUMP_EMIT: begin
          if (out_free) begin
            status    <= olie_pkg::ST_OK;
            count     <= olie_pkg::COUNT_W'(cnt);
            element   <= rd_data;
            last      <= (rem == '0);
            state     <= (rem == '0) ? IDLE : DUMP_RD;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("element count above capacity");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (we && re) |-> (waddr != raddr))
    else $error("shift sweep reads and writes the same entry");

  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    ##1 (cnt == $past(cnt) || cnt == $past(cnt) + CW'(1) || cnt == $past(cnt) - CW'(1)))
    else $error("element count moved by more than one");

  a_dump_cnt_hold: assert property (@(posedge clk) disable iff (rst)
    (state == DUMP_RD || state == DUMP_EMIT) |=> $stable(cnt))
    else $error("element count changed during dump");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(element) && $stable(last)))
    else $error("waiting result overwritten");

endmodule

/* bench/ordered_list_checker.sv */
// checker for ordered_list_insert_erase: watches both channels, keeps its own copy
// of the list and compares every result with the oldest one still owed
// depends on olie_pkg
module ordered_list_checker #(
  parameter int DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  input  logic                                 req_stall,
  input  logic [olie_pkg::KIND_W-1:0]          kind,
  input  logic [olie_pkg::POS_W-1:0]           position,
  input  logic signed [olie_pkg::DATA_W-1:0]   value,
  input  logic                                 res_valid,
  input  logic                                 res_stall,
  input  logic [olie_pkg::STATUS_W-1:0]        status,
  input  logic [olie_pkg::COUNT_W-1:0]         count,
  input  logic signed [olie_pkg::DATA_W-1:0]   element,
  input  logic                                 last,
  output int                                   mismatches,
  output int                                   owed_count,
  output int                                   list_len,
  output int                                   results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [olie_pkg::STATUS_W-1:0]        st;
    logic [olie_pkg::COUNT_W-1:0]         cnt;
    logic signed [olie_pkg::DATA_W-1:0]   elem;
    logic                                 fin;
  } list_result_t;

  logic signed [olie_pkg::DATA_W-1:0] slots [DEPTH];
  int                                 len;
  list_result_t                       owed_results [$];

  // applies one request to the shadow list and queues the results it owes
  function automatic void apply_list_op(logic [olie_pkg::KIND_W-1:0] op,
                                        logic [olie_pkg::POS_W-1:0] idx,
                                        logic signed [olie_pkg::DATA_W-1:0] data);
    logic [olie_pkg::STATUS_W-1:0] st;
    int                            i;
    st = olie_pkg::ST_OK;
    case (op)
      olie_pkg::KIND_PUSH_BACK: begin
        if (len >= DEPTH) st = olie_pkg::ST_FULL;
        else begin
          slots[len] = data;
          len++;
        end
      end
      olie_pkg::KIND_POP_BACK: begin
        if (len == 0) st = olie_pkg::ST_EMPTY;
        else len--;
      end
      olie_pkg::KIND_POP_FRONT: begin
        if (len == 0) st = olie_pkg::ST_EMPTY;
        else begin
          for (i = 1; i < len; i++) slots[i-1] = slots[i];
          len--;
        end
      end
      olie_pkg::KIND_INSERT: begin
        // full takes priority over a bad position
        if (len >= DEPTH) st = olie_pkg::ST_FULL;
        else if (int'(idx) >= len) st = olie_pkg::ST_POS;
        else begin
          for (i = len; i > int'(idx); i--) slots[i] = slots[i-1];
          slots[idx] = data;
          len++;
        end
      end
      olie_pkg::KIND_ERASE: begin
        if (len == 0) st = olie_pkg::ST_EMPTY;
        else if (int'(idx) >= len) st = olie_pkg::ST_POS;
        else begin
          for (i = int'(idx); i + 1 < len; i++) slots[i] = slots[i+1];
          len--;
        end
      end
      olie_pkg::KIND_DUMP: begin
        if (len == 0)
          owed_results.push_back('{olie_pkg::ST_EMPTY, olie_pkg::COUNT_W'(0),
                                   olie_pkg::DATA_W'(0), 1'b1});
        else begin
          for (i = 0; i < len; i++)
            owed_results.push_back('{olie_pkg::ST_OK, olie_pkg::COUNT_W'(len), slots[i],
                                     1'(i == len - 1)});
        end
        return;
      end
      default: return;  // unused kinds produce nothing
    endcase
    owed_results.push_back('{st, olie_pkg::COUNT_W'(len), olie_pkg::DATA_W'(0), 1'b1});
  endfunction

  always @(posedge clk) begin : watch
    list_result_t got;
    list_result_t want;
    if (rst) begin
      len = 0;
      owed_results.delete();
      mismatches = 0;
      results_checked = 0;
    end else begin
      if (res_valid && !res_stall) begin
        got = '{status, count, element, last};
        if (owed_results.size() == 0) begin
          $error("unexpected result: status %0d count %0d element %0d last %0d",
                 status, count, element, last);
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          results_checked++;
          if (got.st !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, got.st);
            mismatches++;
          end
          if (got.cnt !== want.cnt) begin
            $error("count: expected %0d, got %0d", want.cnt, got.cnt);
            mismatches++;
          end
          if (got.elem !== want.elem) begin
            $error("element: expected %0d, got %0d", want.elem, got.elem);
            mismatches++;
          end
          if (got.fin !== want.fin) begin
            $error("last: expected %0d, got %0d", want.fin, got.fin);
            mismatches++;
          end
        end
      end
      if (req_valid && !req_stall) apply_list_op(kind, position, value);
    end
    owed_count = owed_results.size();
    list_len = len;
  end

endmodule

/* bench/ordered_list_insert_erase_tb.sv */
// top of the ordered list bench: clock, reset, request and stall stimulus, verdict
// depends on olie_pkg, ordered_list_insert_erase and ordered_list_checker
module ordered_list_insert_erase_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = 32;
  localparam int RANDOM_ITEMS = 350;
  localparam int STUCK_LIMIT  = 4000;
  localparam int SETTLE       = 80;

  localparam logic [olie_pkg::KIND_W-1:0] KIND_SPARE_A = 3'd6;
  localparam logic [olie_pkg::KIND_W-1:0] KIND_SPARE_B = 3'd7;

  typedef enum int { MODE_FILL, MODE_DRAIN, MODE_CHURN } traffic_mode_t;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 req_valid = 1'b0;
  logic                                 req_stall;
  logic [olie_pkg::KIND_W-1:0]          kind = '0;
  logic [olie_pkg::POS_W-1:0]           position = '0;
  logic signed [olie_pkg::DATA_W-1:0]   value = '0;
  logic                                 res_valid;
  logic                                 res_stall = 1'b0;
  logic [olie_pkg::STATUS_W-1:0]        status;
  logic [olie_pkg::COUNT_W-1:0]         count;
  logic signed [olie_pkg::DATA_W-1:0]   element;
  logic                                 last;

  int mismatches, owed_count, list_len, results_checked;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int stuck_cycles = 0;
  int requests_sent = 0;
  int dumps_sent = 0;
  int seen_full = 0;
  int seen_empty = 0;

  always #4 clk = ~clk;

  ordered_list_insert_erase #(.DEPTH(DEPTH)) uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .kind(kind), .position(position), .value(value),
    .res_valid(res_valid), .res_stall(res_stall),
    .status(status), .count(count), .element(element), .last(last)
  );

  ordered_list_checker #(.DEPTH(DEPTH)) list_chk (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .kind(kind), .position(position), .value(value),
    .res_valid(res_valid), .res_stall(res_stall),
    .status(status), .count(count), .element(element), .last(last),
    .mismatches(mismatches), .owed_count(owed_count),
    .list_len(list_len), .results_checked(results_checked)
  );

  always @(negedge clk) res_stall = ($urandom_range(0, 99) < stall_pct);

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_request(input logic [olie_pkg::KIND_W-1:0] op,
                              input logic [olie_pkg::POS_W-1:0] idx,
                              input logic signed [olie_pkg::DATA_W-1:0] data);
    // rotate through idle patterns so gaps hit every phase of the list
    case ((requests_sent / 25) % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 54; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 54; end
      default: begin send_idle_pct = 19; stall_pct = 19; end
    endcase
    if (list_len == DEPTH) seen_full++;
    if (list_len == 0) seen_empty++;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid = 1'b1;
    kind = op;
    position = idx;
    value = data;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
    requests_sent++;
    if (op == olie_pkg::KIND_DUMP) dumps_sent++;
  endtask

  initial begin
    traffic_mode_t                      mode;
    int                                 counted;
    int                                 pick;
    logic [olie_pkg::KIND_W-1:0]        op;
    logic [olie_pkg::POS_W-1:0]         idx;
    logic signed [olie_pkg::DATA_W-1:0] data;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty list corner cases
    send_request(olie_pkg::KIND_DUMP, '0, '0);
    send_request(olie_pkg::KIND_POP_BACK, '0, '0);
    send_request(olie_pkg::KIND_POP_FRONT, '0, '0);
    send_request(olie_pkg::KIND_ERASE, '0, '0);
    send_request(olie_pkg::KIND_INSERT, '0, 32'sh1234_5678);
    send_request(KIND_SPARE_A, 5'd31, -32'sd1);
    send_request(KIND_SPARE_B, 5'd31, -32'sd1);
    // value extremes, then inserts at head and middle
    send_request(olie_pkg::KIND_PUSH_BACK, 5'd31, 32'sh7fff_ffff);
    send_request(olie_pkg::KIND_PUSH_BACK, '0, 32'sh8000_0000);
    send_request(olie_pkg::KIND_PUSH_BACK, '0, '0);
    send_request(olie_pkg::KIND_PUSH_BACK, '0, -32'sd1);
    send_request(olie_pkg::KIND_INSERT, '0, 32'sh5555_5555);
    send_request(olie_pkg::KIND_INSERT, 5'd3, 32'shaaaa_aaaa);
    // positions at and beyond the count, then in-range erases, pops and dumps
    send_request(olie_pkg::KIND_INSERT, 5'd6, 32'sd7);
    send_request(olie_pkg::KIND_INSERT, 5'd31, 32'sd7);
    send_request(olie_pkg::KIND_ERASE, 5'd31, '0);
    send_request(olie_pkg::KIND_ERASE, 5'd6, '0);
    send_request(olie_pkg::KIND_DUMP, '0, '0);
    send_request(olie_pkg::KIND_ERASE, 5'd5, '0);
    send_request(olie_pkg::KIND_ERASE, '0, '0);
    send_request(olie_pkg::KIND_ERASE, 5'd2, '0);
    send_request(olie_pkg::KIND_POP_FRONT, '0, '0);
    send_request(olie_pkg::KIND_POP_BACK, '0, '0);
    send_request(olie_pkg::KIND_DUMP, '0, '0);

    mode = MODE_FILL;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (mode == MODE_FILL && list_len == DEPTH && $urandom_range(0, 3) == 0)
        mode = MODE_DRAIN;
      else if (mode == MODE_DRAIN && list_len == 0 && $urandom_range(0, 2) == 0)
        mode = $urandom_range(0, 1) ? MODE_CHURN : MODE_FILL;
      else if (mode == MODE_CHURN && $urandom_range(0, 39) == 0)
        mode = MODE_FILL;

      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 49) == 0) op = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
      else if (mode == MODE_FILL)
        op = pick < 40 ? olie_pkg::KIND_PUSH_BACK : pick < 75 ? olie_pkg::KIND_INSERT :
             pick < 82 ? olie_pkg::KIND_DUMP : pick < 88 ? olie_pkg::KIND_ERASE :
             pick < 94 ? olie_pkg::KIND_POP_BACK : olie_pkg::KIND_POP_FRONT;
      else if (mode == MODE_DRAIN)
        op = pick < 25 ? olie_pkg::KIND_POP_BACK : pick < 50 ? olie_pkg::KIND_POP_FRONT :
             pick < 85 ? olie_pkg::KIND_ERASE : pick < 92 ? olie_pkg::KIND_DUMP :
             olie_pkg::KIND_INSERT;
      else op = olie_pkg::KIND_W'($urandom_range(0, 5));

      // mostly in-range positions, the rest anywhere in the field
      if (list_len > 0 && $urandom_range(0, 99) < 85)
        idx = olie_pkg::POS_W'($urandom_range(0, list_len - 1));
      else idx = olie_pkg::POS_W'($urandom_range(0, 31));
      case ($urandom_range(0, 19))
        0: data = 32'sh8000_0000;
        1: data = 32'sh7fff_ffff;
        default: data = $urandom;
      endcase

      send_request(op, idx, data);
      if (op != KIND_SPARE_A && op != KIND_SPARE_B) counted++;
    end

    req_valid = 1'b0;
    while (owed_count != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("sent %0d list requests including %0d dumps; %0d results compared",
             requests_sent, dumps_sent, results_checked);
    $display("requests met a full list %0d times and an empty one %0d times; %0d mismatches",
             seen_full, seen_empty, mismatches);
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* ordered_list_insert_erase.f */
hw/rtl/olie_pkg.sv
hw/rtl/ordered_list_insert_erase.sv
bench/ordered_list_checker.sv
bench/ordered_list_insert_erase_tb.sv
